>>> src/assert_macros.svh
// Assertion macros used by the RTL of the serial ring buffer block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks a property on every rising clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");

// Checks that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> src/srtrb_pkg.sv
// Package with opcodes, field widths and the result word type of the ring buffer block.
package srtrb_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned ByteW = 8;
  localparam int unsigned FillW = 5;

  localparam logic [OpW-1:0] OP_RX_PUSH = 3'd0;
  localparam logic [OpW-1:0] OP_RX_POP  = 3'd1;
  localparam logic [OpW-1:0] OP_TX_PUSH = 3'd2;
  localparam logic [OpW-1:0] OP_TX_DONE = 3'd3;
  localparam logic [OpW-1:0] OP_SERVICE = 3'd4;

  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 32;

  typedef struct packed {
    logic             sending;
    logic [FillW-1:0] tx_fill;
    logic [FillW-1:0] rx_fill;
    logic [ByteW-1:0] launch_byte;
    logic             launch;
    logic             read_valid;
    logic [ByteW-1:0] read_byte;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

endpackage

>>> src/serial_rx_tx_ring_buffers_top.sv
// Receive and transmit byte ring buffers with a transmit-busy flag.
//
// Channel   Dir  Fields of tdata, lowest bit first
// s_axis    in   opcode[2:0], data_byte[10:3], zero fill to 16 bits
// m_axis    out  read_byte[7:0], read_valid[8], launch[9], launch_byte[17:10],
//                rx_fill[22:18], tx_fill[27:23], sending[28], zero fill to 32 bits
//
// A word that pops a buffer first reads the synchronous store, then loads the result
// register. Every other word loads the result register directly.
// Reset clears pointers, levels, the busy flag and the result register.
// The result register frees the input side as soon as the result is taken.
`include "assert_macros.svh"

module serial_rx_tx_ring_buffers_top
  import srtrb_pkg::*;
#(
  parameter int unsigned RX_DEPTH = 16,
  parameter int unsigned TX_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,   // opcode, data_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [OutDataW-1:0] m_axis_tdata_o    // read_byte, read_valid, launch,
                                                // launch_byte, rx_fill, tx_fill, sending
);

  localparam int unsigned RxPw = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int unsigned TxPw = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned RxLw = $clog2(RX_DEPTH + 1);
  localparam int unsigned TxLw = $clog2(TX_DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic [ByteW-1:0] rx_mem [RX_DEPTH];
  logic [ByteW-1:0] tx_mem [TX_DEPTH];
  logic [ByteW-1:0] rx_rdata_q, tx_rdata_q;

  logic            state_q, state_d;
  logic [RxPw-1:0] rx_wp_q, rx_wp_d, rx_rp_q, rx_rp_d, rx_wp_nxt, rx_rp_nxt;
  logic [TxPw-1:0] tx_wp_q, tx_wp_d, tx_rp_q, tx_rp_d, tx_wp_nxt, tx_rp_nxt;
  logic [RxLw-1:0] rx_lvl_q, rx_lvl_d;
  logic [TxLw-1:0] tx_lvl_q, tx_lvl_d;
  logic            busy_q, busy_d;
  logic            out_vld_q, out_vld_d;
  res_t            out_q, out_d;
  logic            rx_we, tx_we, rx_re, tx_re;
  logic            accept;
  logic [OpW-1:0]  op;
  logic [ByteW-1:0] din;

  assign op     = s_axis_tdata_i[OpW-1:0];
  assign din    = s_axis_tdata_i[OpW+ByteW-1:OpW];
  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_vld_q || m_axis_tready_i);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = OutDataW'(out_q);

  assign rx_wp_nxt = (rx_wp_q == RxPw'(RX_DEPTH - 1)) ? '0 : rx_wp_q + 1'b1;
  assign rx_rp_nxt = (rx_rp_q == RxPw'(RX_DEPTH - 1)) ? '0 : rx_rp_q + 1'b1;
  assign tx_wp_nxt = (tx_wp_q == TxPw'(TX_DEPTH - 1)) ? '0 : tx_wp_q + 1'b1;
  assign tx_rp_nxt = (tx_rp_q == TxPw'(TX_DEPTH - 1)) ? '0 : tx_rp_q + 1'b1;

  always_comb begin
    state_d   = state_q;
    rx_wp_d   = rx_wp_q;
    rx_rp_d   = rx_rp_q;
    rx_lvl_d  = rx_lvl_q;
    tx_wp_d   = tx_wp_q;
    tx_rp_d   = tx_rp_q;
    tx_lvl_d  = tx_lvl_q;
    busy_d    = busy_q;
    out_d     = out_q;
    out_vld_d = out_vld_q;
    rx_we     = 1'b0;
    tx_we     = 1'b0;
    rx_re     = 1'b0;
    tx_re     = 1'b0;

    if (out_vld_q && m_axis_tready_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_d = '0;
          unique case (op)
            OP_RX_PUSH: begin
              rx_we   = 1'b1;
              rx_wp_d = rx_wp_nxt;
              if (rx_lvl_q == RxLw'(RX_DEPTH)) begin
                rx_rp_d = rx_rp_nxt;
              end else begin
                rx_lvl_d = rx_lvl_q + 1'b1;
              end
            end
            OP_RX_POP: begin
              if (rx_lvl_q != '0) begin
                rx_re            = 1'b1;
                rx_rp_d          = rx_rp_nxt;
                rx_lvl_d         = rx_lvl_q - 1'b1;
                out_d.read_valid = 1'b1;
              end
            end
            OP_TX_PUSH: begin
              tx_we   = 1'b1;
              tx_wp_d = tx_wp_nxt;
              if (tx_lvl_q == TxLw'(TX_DEPTH)) begin
                tx_rp_d = tx_rp_nxt;
              end else begin
                tx_lvl_d = tx_lvl_q + 1'b1;
              end
            end
            OP_TX_DONE: begin
              busy_d = 1'b0;
            end
            OP_SERVICE: begin
              if (tx_lvl_q != '0 && !busy_q) begin
                tx_re        = 1'b1;
                tx_rp_d      = tx_rp_nxt;
                tx_lvl_d     = tx_lvl_q - 1'b1;
                busy_d       = 1'b1;
                out_d.launch = 1'b1;
              end
            end
            default: begin
            end
          endcase
          out_d.rx_fill = FillW'(rx_lvl_d);
          out_d.tx_fill = FillW'(tx_lvl_d);
          out_d.sending = busy_d;
          if (rx_re || tx_re) begin
            state_d = ST_READ;
          end else begin
            out_vld_d = 1'b1;
          end
        end
      end
      ST_READ: begin
        state_d   = ST_IDLE;
        out_vld_d = 1'b1;
        if (out_q.read_valid) begin
          out_d.read_byte = rx_rdata_q;
        end
        if (out_q.launch) begin
          out_d.launch_byte = tx_rdata_q;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rx_wp_q   <= '0;
      rx_rp_q   <= '0;
      rx_lvl_q  <= '0;
      tx_wp_q   <= '0;
      tx_rp_q   <= '0;
      tx_lvl_q  <= '0;
      busy_q    <= 1'b0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      rx_wp_q   <= rx_wp_d;
      rx_rp_q   <= rx_rp_d;
      rx_lvl_q  <= rx_lvl_d;
      tx_wp_q   <= tx_wp_d;
      tx_rp_q   <= tx_rp_d;
      tx_lvl_q  <= tx_lvl_d;
      busy_q    <= busy_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  // A push is written at an earlier edge than any later pop can read, so no bypass is needed.
  always_ff @(posedge clk_i) begin
    if (rx_we) begin
      rx_mem[rx_wp_q] <= din;
    end
    if (rx_re) begin
      rx_rdata_q <= rx_mem[rx_rp_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (tx_we) begin
      tx_mem[tx_wp_q] <= din;
    end
    if (tx_re) begin
      tx_rdata_q <= tx_mem[tx_rp_q];
    end
  end

  `ASSERT_NEVER(rx_level_ovf, clk_i, rst_ni, rx_lvl_q > RxLw'(RX_DEPTH))
  `ASSERT_NEVER(tx_level_ovf, clk_i, rst_ni, tx_lvl_q > TxLw'(TX_DEPTH))
  `ASSERT_NEVER(read_out_clash, clk_i, rst_ni, state_q == ST_READ && out_vld_q)
  `ASSERT_PROP(launch_sets_busy, clk_i, rst_ni, out_vld_q && out_q.launch |-> out_q.sending)
  `ASSERT_PROP(read_follows_pop, clk_i, rst_ni, (rx_re || tx_re) |=> state_q == ST_READ)

endmodule

>>> sim/tb_serial_rx_tx_ring_buffers_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the serial receive and transmit ring buffer block.
module tb_serial_rx_tx_ring_buffers_top;
  import srtrb_pkg::*;

  localparam int unsigned RxDepth = 16;
  localparam int unsigned TxDepth = 16;
  localparam int unsigned RxPtrW  = $clog2(RxDepth);
  localparam int unsigned TxPtrW  = $clog2(TxDepth);

  localparam logic [OpW-1:0] OpUnusedLo = 3'd5;
  localparam logic [OpW-1:0] OpUnusedHi = 3'd7;

  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i  = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;

  logic [ByteW-1:0]  rx_mem [RxDepth];
  logic [RxPtrW-1:0] rx_wr  = '0;
  logic [RxPtrW-1:0] rx_rd  = '0;
  logic [FillW-1:0]  rx_cnt = '0;
  logic [ByteW-1:0]  tx_mem [TxDepth];
  logic [TxPtrW-1:0] tx_wr  = '0;
  logic [TxPtrW-1:0] tx_rd  = '0;
  logic [FillW-1:0]  tx_cnt = '0;
  logic              tx_busy = 1'b0;

  res_t        pending_status [$];
  int unsigned src_idle_pct = 12;
  int unsigned snk_idle_pct = 76;
  int unsigned errors       = 0;

  serial_rx_tx_ring_buffers_top #(
    .RX_DEPTH(RxDepth),
    .TX_DEPTH(TxDepth)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Applies one word to the buffer state and returns the status word it should produce.
  function automatic res_t buffers_step(logic [OpW-1:0] op, logic [ByteW-1:0] b);
    res_t r;
    r = '0;
    case (op)
      OP_RX_PUSH: begin
        rx_mem[rx_wr] = b;
        rx_wr = (rx_wr == RxPtrW'(RxDepth - 1)) ? '0 : rx_wr + 1'b1;
        if (rx_cnt == FillW'(RxDepth)) begin
          rx_rd = (rx_rd == RxPtrW'(RxDepth - 1)) ? '0 : rx_rd + 1'b1;
        end else begin
          rx_cnt = rx_cnt + 1'b1;
        end
      end
      OP_RX_POP: begin
        if (rx_cnt != 0) begin
          r.read_byte  = rx_mem[rx_rd];
          r.read_valid = 1'b1;
          rx_rd = (rx_rd == RxPtrW'(RxDepth - 1)) ? '0 : rx_rd + 1'b1;
          rx_cnt = rx_cnt - 1'b1;
        end
      end
      OP_TX_PUSH: begin
        tx_mem[tx_wr] = b;
        tx_wr = (tx_wr == TxPtrW'(TxDepth - 1)) ? '0 : tx_wr + 1'b1;
        if (tx_cnt == FillW'(TxDepth)) begin
          tx_rd = (tx_rd == TxPtrW'(TxDepth - 1)) ? '0 : tx_rd + 1'b1;
        end else begin
          tx_cnt = tx_cnt + 1'b1;
        end
      end
      OP_TX_DONE: begin
        tx_busy = 1'b0;
      end
      OP_SERVICE: begin
        if (tx_cnt != 0 && !tx_busy) begin
          r.launch      = 1'b1;
          r.launch_byte = tx_mem[tx_rd];
          tx_rd = (tx_rd == TxPtrW'(TxDepth - 1)) ? '0 : tx_rd + 1'b1;
          tx_cnt = tx_cnt - 1'b1;
          tx_busy = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.rx_fill = rx_cnt;
    r.tx_fill = tx_cnt;
    r.sending = tx_busy;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("tb: mismatch at %0t ns: %s", $time, msg);
    errors++;
  endtask

  task automatic check_field(string name, logic [ByteW-1:0] got, logic [ByteW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  always @(posedge clk_i) begin
    res_t got;
    res_t want;
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        pending_status.push_back(buffers_step(s_axis_tdata_i[OpW-1:0],
                                              s_axis_tdata_i[OpW +: ByteW]));
      end
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = res_t'(m_axis_tdata_o[ResW-1:0]);
        if (pending_status.size() == 0) begin
          report_mismatch("result word with nothing expected");
        end else begin
          want = pending_status.pop_front();
          check_field("read_byte", got.read_byte, want.read_byte);
          check_field("read_valid", ByteW'(got.read_valid), ByteW'(want.read_valid));
          check_field("launch", ByteW'(got.launch), ByteW'(want.launch));
          check_field("launch_byte", got.launch_byte, want.launch_byte);
          check_field("rx_fill", ByteW'(got.rx_fill), ByteW'(want.rx_fill));
          check_field("tx_fill", ByteW'(got.tx_fill), ByteW'(want.tx_fill));
          check_field("sending", ByteW'(got.sending), ByteW'(want.sending));
        end
      end
    end
  end

  task automatic send_word(logic [OpW-1:0] op, logic [ByteW-1:0] b);
    if ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < src_idle_pct) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= InDataW'({b, op});
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic test_empty_buffers();
    send_word(OP_RX_POP, 8'hFF);
    send_word(OP_SERVICE, 8'hFF);
    send_word(OP_TX_DONE, 8'h00);
  endtask

  // The seventeenth byte overwrites the oldest, so the pop returns the second byte.
  task automatic test_rx_overflow();
    int unsigned i;
    send_word(OP_RX_PUSH, 8'h00);
    send_word(OP_RX_PUSH, 8'hFF);
    for (i = 2; i <= RxDepth; i++) begin
      send_word(OP_RX_PUSH, ByteW'(i * 37));
    end
    send_word(OP_RX_POP, 8'h00);
  endtask

  task automatic test_tx_launch();
    send_word(OP_TX_PUSH, 8'h5A);
    send_word(OP_SERVICE, 8'h00);
    send_word(OP_SERVICE, 8'hFF);
    send_word(OP_TX_DONE, 8'hFF);
  endtask

  task automatic test_unused_opcodes();
    send_word(OpUnusedLo, 8'hFF);
    send_word(OpUnusedLo + 1'b1, 8'h00);
    send_word(OpUnusedHi, 8'hAA);
  endtask

  // Traffic switches at random, in blocks of 64 words, between filling and draining the buffers.
  task automatic test_random_traffic(int unsigned n_words, int unsigned src_pct,
                                     int unsigned snk_pct);
    int unsigned     i;
    int unsigned     pick;
    bit              fill_heavy;
    logic [OpW-1:0]  op;
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    fill_heavy   = 1'b0;
    for (i = 0; i < n_words; i++) begin
      if (i % 64 == 0) fill_heavy = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 3) begin
        op = OpW'($urandom_range(OpUnusedHi, OpUnusedLo));
      end else if (pick < (fill_heavy ? 38 : 18)) begin
        op = OP_RX_PUSH;
      end else if (pick < (fill_heavy ? 46 : 48)) begin
        op = OP_RX_POP;
      end else if (pick < (fill_heavy ? 76 : 63)) begin
        op = OP_TX_PUSH;
      end else if (pick < (fill_heavy ? 86 : 80)) begin
        op = OP_TX_DONE;
      end else begin
        op = OP_SERVICE;
      end
      send_word(op, ByteW'($urandom_range(255)));
    end
  endtask

  initial begin
    int unsigned drain_cycles;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_buffers();
    test_rx_overflow();
    test_tx_launch();
    test_unused_opcodes();
    test_random_traffic(430, 12, 76);
    test_random_traffic(430, 76, 12);
    test_random_traffic(440, 0, 0);
    s_axis_tvalid_i <= 1'b0;
    drain_cycles = 0;
    while (pending_status.size() != 0 && drain_cycles < 10000) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (8) @(posedge clk_i);
    if (pending_status.size() != 0) begin
      report_mismatch($sformatf("%0d result words never arrived", pending_status.size()));
    end
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/srtrb_pkg.sv
src/serial_rx_tx_ring_buffers_top.sv
sim/tb_serial_rx_tx_ring_buffers_top.sv
